[rtl/brm_pkg.sv]
// Package for the byte register machine execute block: opcodes, status and flag codes, queue entry and result types.
// No dependencies.
package brm_pkg;

  localparam logic [5:0] OP_ADD = 6'd0, OP_SUB = 6'd1, OP_LDI = 6'd2, OP_STR = 6'd3,
    OP_LDM = 6'd4, OP_LDA = 6'd5, OP_STA = 6'd6, OP_PUSH = 6'd7, OP_POP = 6'd8,
    OP_INC = 6'd9, OP_DEC = 6'd10, OP_CMP = 6'd11, OP_JMP = 6'd12, OP_JE = 6'd13,
    OP_JG = 6'd14, OP_JGE = 6'd15, OP_JL = 6'd16, OP_JLE = 6'd17, OP_JNE = 6'd18,
    OP_MUL = 6'd19, OP_DIV = 6'd20, OP_MOD = 6'd21, OP_AND = 6'd22, OP_OR = 6'd23,
    OP_XOR = 6'd24, OP_NOT = 6'd25, OP_SHL = 6'd26, OP_SHR = 6'd27, OP_XCHG = 6'd28,
    OP_ROR = 6'd29, OP_ROL = 6'd30, OP_CALL = 6'd31, OP_RET = 6'd32, OP_STP = 6'd33,
    OP_MOV = 6'd34;

  localparam logic [2:0] ST_OK = 3'd0, ST_ADDR = 3'd1, ST_UNDER = 3'd2, ST_TARGET = 3'd3,
    ST_DIV0 = 3'd4, ST_STOP = 3'd5, ST_OVER = 3'd6;

  localparam logic [1:0] FL_EQ = 2'd0, FL_NEG = 2'd1, FL_POS = 2'd2;

  typedef struct packed {
    logic [5:0] mode;
    logic [7:0] left;
    logic [7:0] right;
    logic [2:0] dest_reg;
    logic [7:0] current_ip;
  } instr_t;

  typedef struct packed {
    logic [2:0] status;
    logic       redirect;
    logic [7:0] next_ip;
    logic [7:0] written_value;
    logic [1:0] flag_state;
  } result_t;

endpackage

[rtl/brm_if.sv]
// Valid/ready channel interface, payload type given as a parameter.
// No dependencies; the payload type is given by the instantiating module.
interface brm_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/brm_ram.sv]
// Generic single-port RAM with registered read.
// No dependencies.
module brm_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

[rtl/brm_front.sv]
// Front end: accepts instructions into a two-entry queue for the back end.
// Depends on brm_pkg and brm_if.
module brm_front (
  input  logic clk_i,
  input  logic rst_ni,
  brm_if.sink   in_i,
  brm_if.source q_o
);
  brm_pkg::instr_t ent_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       rd_q, rd_d, wr_q, wr_d;
  logic       push, pop;

  assign in_i.ready = (cnt_q != 2'd2);
  assign push = in_i.valid && in_i.ready;
  assign pop  = q_o.valid && q_o.ready;
  assign q_o.valid = (cnt_q != 2'd0);
  assign q_o.data  = ent_q[rd_q];

  always_comb begin
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
    rd_d  = rd_q ^ pop;
    wr_d  = wr_q ^ push;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; rd_q <= 1'b0; wr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d; rd_q <= rd_d; wr_q <= wr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) ent_q[wr_q] <= in_i.data;
  end
endmodule

[rtl/brm_div.sv]
// Restoring 8-bit divider, one quotient bit per cycle.
// No dependencies.
module brm_div (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [7:0] num_i,
  input  logic [7:0] den_i,
  output logic       done_o,
  output logic [7:0] quo_o,
  output logic [7:0] rem_o
);
  logic [3:0] cnt_q;
  logic       busy_q;
  logic [7:0] quo_q, den_q;
  logic [8:0] rem_q;
  logic [8:0] trial;

  assign trial  = {rem_q[7:0], quo_q[7]} - {1'b0, den_q};
  assign done_o = busy_q && (cnt_q == 4'd0);
  assign quo_o  = quo_q;
  assign rem_o  = rem_q[7:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1; cnt_q <= 4'd8;
    end else if (busy_q) begin
      if (cnt_q == 4'd0) busy_q <= 1'b0;
      else cnt_q <= cnt_q - 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i; den_q <= den_i; rem_q <= '0;
    end else if (busy_q && cnt_q != 4'd0) begin
      if (!trial[8]) begin
        rem_q <= trial; quo_q <= {quo_q[6:0], 1'b1};
      end else begin
        rem_q <= {rem_q[7:0], quo_q[7]}; quo_q <= {quo_q[6:0], 1'b0};
      end
    end
  end
endmodule

[rtl/brm_back.sv]
// Back end: sequencer that reads operands, accesses memory/stack, divides and writes back.
// Depends on brm_pkg, brm_if, brm_ram and brm_div.
module brm_back #(
  parameter int NUM_REGS    = 8,
  parameter int DATA_WORDS  = 256,
  parameter int STACK_DEPTH = 16,
  parameter int CODE_WORDS  = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [8:0] prog_len_i,
  brm_if.sink   q_i,
  brm_if.source res_o
);
  localparam int RW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int DW = $clog2(DATA_WORDS);
  localparam int SW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  localparam logic [2:0] S_IDLE = 3'd0, S_MEM = 3'd1, S_DIV = 3'd2, S_EXEC = 3'd3,
    S_OUT = 3'd4;

  logic [2:0] state_q, state_d;
  brm_pkg::instr_t ins_q;
  logic [7:0] a_q, b_q;
  logic [7:0] regs_q [NUM_REGS];
  logic [CW-1:0] sp_q;
  logic [1:0] flag_q;
  brm_pkg::result_t res_q;
  logic res_v_q;

  logic [RW-1:0] rl, rr, rd;
  assign rl = ins_q.left[RW-1:0];
  assign rr = ins_q.right[RW-1:0];
  assign rd = RW'(ins_q.dest_reg);

  // memory and stack
  logic mem_we, stk_we;
  logic [DW-1:0] mem_addr;
  logic [SW-1:0] stk_addr;
  logic [7:0] mem_wd, stk_wd, mem_rd, stk_rd;
  logic div_start, div_done;
  logic [7:0] quo, rem;

  brm_ram #(.Width(8), .Depth(DATA_WORDS)) u_dmem (
    .clk_i, .we_i(mem_we), .addr_i(mem_addr), .wdata_i(mem_wd), .rdata_o(mem_rd));
  brm_ram #(.Width(8), .Depth(STACK_DEPTH)) u_stk (
    .clk_i, .we_i(stk_we), .addr_i(stk_addr), .wdata_i(stk_wd), .rdata_o(stk_rd));
  brm_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(a_q), .den_i(b_q),
    .done_o(div_done), .quo_o(quo), .rem_o(rem));

  // data memory needs zero reset: valid bit per word
  logic [DATA_WORDS-1:0] mvld_q;
  logic mvld_rd_q;

  logic stk_full, stk_empty, ind_bad, dir_bad;
  assign stk_full  = (sp_q >= CW'(STACK_DEPTH));
  assign stk_empty = (sp_q == '0);
  assign dir_bad   = ({1'b0, ins_q.right} >= 9'(DATA_WORDS));
  assign ind_bad   = ({1'b0, a_q} >= 9'(DATA_WORDS));

  // memory addresses decided in S_IDLE->S_MEM (read) and S_EXEC (write)
  logic [SW-1:0] sp_m1;
  assign sp_m1 = SW'(sp_q - CW'(1));

  // execute
  logic [2:0] st;
  logic redir, wr_reg, wr_mem, wr_stk, xchg;
  logic [7:0] nip, wv;
  logic [RW-1:0] wr_idx;
  logic [CW-1:0] sp_n;
  logic [1:0] flag_n;
  logic cond;
  logic [7:0] mrd, ra, rl8;
  logic [2:0] s3;

  assign mrd = mvld_rd_q ? mem_rd : 8'd0;
  assign s3  = ins_q.right[2:0];
  assign ra  = (a_q >> s3) | (a_q << (4'd8 - {1'b0, s3}));
  assign rl8 = (a_q << s3) | (a_q >> (4'd8 - {1'b0, s3}));

  always_comb begin
    st = brm_pkg::ST_OK; redir = 1'b0; nip = ins_q.current_ip; wv = 8'd0;
    wr_reg = 1'b0; wr_mem = 1'b0; wr_stk = 1'b0; xchg = 1'b0; wr_idx = rl;
    sp_n = sp_q; flag_n = flag_q; cond = 1'b0;
    unique case (ins_q.mode)
      brm_pkg::OP_ADD: begin wv = a_q + b_q; wr_reg = 1'b1; wr_idx = rd; end
      brm_pkg::OP_SUB: begin wv = a_q - b_q; wr_reg = 1'b1; wr_idx = rd; end
      brm_pkg::OP_LDI: begin wv = ins_q.right; wr_reg = 1'b1; end
      brm_pkg::OP_STR: if (dir_bad) st = brm_pkg::ST_ADDR;
                       else begin wv = a_q; wr_mem = 1'b1; end
      brm_pkg::OP_LDM: if (dir_bad) st = brm_pkg::ST_ADDR;
                       else begin wv = mrd; wr_reg = 1'b1; end
      brm_pkg::OP_LDA: if (ind_bad) st = brm_pkg::ST_ADDR;
                       else begin wv = mrd; wr_reg = 1'b1; wr_idx = rr; end
      brm_pkg::OP_STA: if (ind_bad) st = brm_pkg::ST_ADDR;
                       else begin wv = b_q; wr_mem = 1'b1; end
      brm_pkg::OP_PUSH: if (stk_full) st = brm_pkg::ST_OVER;
                        else begin wv = a_q; wr_stk = 1'b1; sp_n = sp_q + CW'(1); end
      brm_pkg::OP_POP: if (stk_empty) st = brm_pkg::ST_UNDER;
                       else begin wv = stk_rd; wr_reg = 1'b1; sp_n = sp_q - CW'(1); end
      brm_pkg::OP_INC: begin wv = a_q + 8'd1; wr_reg = 1'b1; end
      brm_pkg::OP_DEC: begin wv = a_q - 8'd1; wr_reg = 1'b1; end
      brm_pkg::OP_CMP: flag_n = (a_q == b_q) ? brm_pkg::FL_EQ :
                                (a_q < b_q) ? brm_pkg::FL_NEG : brm_pkg::FL_POS;
      brm_pkg::OP_JMP, brm_pkg::OP_JE, brm_pkg::OP_JG, brm_pkg::OP_JGE, brm_pkg::OP_JL,
      brm_pkg::OP_JLE, brm_pkg::OP_JNE: begin
        case (ins_q.mode)
          brm_pkg::OP_JMP: cond = 1'b1;
          brm_pkg::OP_JE:  cond = (flag_q == brm_pkg::FL_EQ);
          brm_pkg::OP_JG:  cond = (flag_q == brm_pkg::FL_POS);
          brm_pkg::OP_JGE: cond = (flag_q != brm_pkg::FL_NEG);
          brm_pkg::OP_JL:  cond = (flag_q == brm_pkg::FL_NEG);
          brm_pkg::OP_JLE: cond = (flag_q != brm_pkg::FL_POS);
          default:         cond = (flag_q != brm_pkg::FL_EQ);
        endcase
        if ({1'b0, ins_q.left} >= prog_len_i) st = brm_pkg::ST_TARGET;
        else if (cond) begin redir = 1'b1; nip = ins_q.left; end
      end
      brm_pkg::OP_MUL: begin wv = 8'(a_q * b_q); wr_reg = 1'b1; wr_idx = rd; end
      brm_pkg::OP_DIV: if (b_q == 8'd0) st = brm_pkg::ST_DIV0;
                       else begin wv = quo; wr_reg = 1'b1; wr_idx = rd; end
      brm_pkg::OP_MOD: if (b_q == 8'd0) st = brm_pkg::ST_DIV0;
                       else begin wv = rem; wr_reg = 1'b1; wr_idx = rd; end
      brm_pkg::OP_AND: begin wv = a_q & b_q; wr_reg = 1'b1; wr_idx = rd; end
      brm_pkg::OP_OR:  begin wv = a_q | b_q; wr_reg = 1'b1; wr_idx = rd; end
      brm_pkg::OP_XOR: begin wv = a_q ^ b_q; wr_reg = 1'b1; wr_idx = rd; end
      brm_pkg::OP_NOT: begin wv = ~a_q; wr_reg = 1'b1; wr_idx = rr; end
      brm_pkg::OP_SHL: begin wv = (ins_q.right >= 8'd8) ? 8'd0 : (a_q << s3); wr_reg = 1'b1; end
      brm_pkg::OP_SHR: begin wv = (ins_q.right >= 8'd8) ? 8'd0 : (a_q >> s3); wr_reg = 1'b1; end
      brm_pkg::OP_XCHG: begin wv = (rl == rr) ? a_q : b_q; xchg = 1'b1; end
      brm_pkg::OP_ROR: begin wv = (s3 == 3'd0) ? a_q : ra; wr_reg = 1'b1; end
      brm_pkg::OP_ROL: begin wv = (s3 == 3'd0) ? a_q : rl8; wr_reg = 1'b1; end
      brm_pkg::OP_CALL:
        if ({1'b0, ins_q.left} >= 9'(CODE_WORDS)) st = brm_pkg::ST_TARGET;
        else if (stk_full) st = brm_pkg::ST_OVER;
        else begin
          wv = ins_q.current_ip; wr_stk = 1'b1; sp_n = sp_q + CW'(1);
          redir = 1'b1; nip = ins_q.left;
        end
      brm_pkg::OP_RET:
        if (stk_empty) st = brm_pkg::ST_UNDER;
        else if ({1'b0, stk_rd} >= 9'(CODE_WORDS)) st = brm_pkg::ST_TARGET;
        else begin sp_n = sp_q - CW'(1); redir = 1'b1; nip = stk_rd; end
      brm_pkg::OP_STP: st = brm_pkg::ST_STOP;
      brm_pkg::OP_MOV: begin wv = b_q; wr_reg = 1'b1; end
      default: ;
    endcase
  end

  logic in_fire, exec;
  assign in_fire = q_i.valid && q_i.ready;
  assign exec = (state_q == S_EXEC);
  // take a new request only once the result register is free or being emptied
  assign q_i.ready = (state_q == S_IDLE) && (!res_v_q || res_o.ready);
  assign res_o.valid = res_v_q;
  assign res_o.data  = res_q;
  assign div_start = (state_q == S_MEM) &&
                     (ins_q.mode == brm_pkg::OP_DIV || ins_q.mode == brm_pkg::OP_MOD);

  // S_MEM: operands in a_q/b_q, issue reads; addresses from a_q in S_MEM
  always_comb begin
    mem_addr = ins_q.right[DW-1:0];
    if (ins_q.mode == brm_pkg::OP_LDA || ins_q.mode == brm_pkg::OP_STA) mem_addr = a_q[DW-1:0];
    mem_we = exec && wr_mem && (st == brm_pkg::ST_OK);
    mem_wd = wv;
    stk_addr = (exec && wr_stk) ? sp_q[SW-1:0] : sp_m1;
    stk_we = exec && wr_stk && (st == brm_pkg::ST_OK);
    stk_wd = wv;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_fire) state_d = S_MEM;
      S_MEM:  state_d = div_start ? S_DIV : S_EXEC;
      S_DIV:  if (div_done) state_d = S_EXEC;
      S_EXEC: state_d = S_OUT;
      S_OUT:  if (!res_v_q || res_o.ready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; sp_q <= '0; flag_q <= brm_pkg::FL_EQ; res_v_q <= 1'b0;
      mvld_q <= '0;
      for (int i = 0; i < NUM_REGS; i++) regs_q[i] <= 8'd0;
    end else begin
      state_q <= state_d;
      if (res_o.ready) res_v_q <= 1'b0;
      if (state_q == S_OUT && state_d == S_IDLE) res_v_q <= 1'b1;
      if (exec && st == brm_pkg::ST_OK) begin
        sp_q <= sp_n; flag_q <= flag_n;
        if (wr_reg) regs_q[wr_idx] <= wv;
        if (xchg) begin regs_q[rl] <= b_q; regs_q[rr] <= a_q; end
        if (wr_mem) mvld_q[mem_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) ins_q <= q_i.data;
    if (state_q == S_IDLE) begin
      a_q <= regs_q[q_i.data.left[RW-1:0]];
      b_q <= regs_q[q_i.data.right[RW-1:0]];
    end
    if (state_q == S_MEM) mvld_rd_q <= mvld_q[mem_addr];
    if (exec) begin
      res_q.status <= st;
      res_q.redirect <= redir;
      res_q.next_ip <= (st == brm_pkg::ST_OK) ? nip : ins_q.current_ip;
      res_q.written_value <= (st == brm_pkg::ST_OK) ? wv : 8'd0;
      res_q.flag_state <= (st == brm_pkg::ST_OK) ? flag_n : flag_q;
    end
  end
endmodule

[rtl/byte_register_machine_execute.sv]
// Execute block of a small 8-bit register machine; one result per instruction.
// Path from accept to result register: S_IDLE, S_MEM, S_DIV for div/mod (8-step divider), S_EXEC, S_OUT.
// The back-end sequencer takes a new instruction only in S_IDLE, once the previous one is through.
// Reset clears registers, compare flag, stack count and memory valid bits at once.
// Depends on brm_pkg, brm_if, brm_front, brm_back.
module byte_register_machine_execute #(
  parameter int NUM_REGS    = 8,
  parameter int DATA_WORDS  = 256,
  parameter int STACK_DEPTH = 16,
  parameter int CODE_WORDS  = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [8:0] cfg_wdata_i,
  brm_if.sink   in_i,
  brm_if.source out_o
);
  // program length register, reset to full code space
  logic [8:0] prog_len_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) prog_len_q <= 9'd256;
    else if (cfg_we_i) prog_len_q <= cfg_wdata_i;
  end

  // front queue decouples the request side from the sequencer
  brm_if #(.T(brm_pkg::instr_t)) q_if ();

  brm_front u_front (.clk_i, .rst_ni, .in_i(in_i), .q_o(q_if.source));

  brm_back #(
    .NUM_REGS(NUM_REGS), .DATA_WORDS(DATA_WORDS),
    .STACK_DEPTH(STACK_DEPTH), .CODE_WORDS(CODE_WORDS)
  ) u_back (
    .clk_i, .rst_ni, .prog_len_i(prog_len_q), .q_i(q_if.sink), .res_o(out_o));
endmodule
